// ----- hw/rtl/fp16_matmul_fp32_accumulate_assert.svh -----
// Assertion macros for the half-precision matrix product block.
`ifndef FP16_MATMUL_FP32_ACCUMULATE_ASSERT_SVH
`define FP16_MATMUL_FP32_ACCUMULATE_ASSERT_SVH
// same-cycle implication
`define FMM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fmm assertion failed");
// next-cycle implication
`define FMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fmm assertion failed");
`endif

// ----- hw/rtl/fmm_pkg.sv -----
// Types and codes shared by the matrix product block.
package fmm_pkg;

   localparam logic [1:0] MODE_LOAD_A    = 2'd0;
   localparam logic [1:0] MODE_LOAD_B    = 2'd1;
   localparam logic [1:0] MODE_LOAD_BIAS = 2'd2;
   localparam logic [1:0] MODE_COMPUTE   = 2'd3;

   localparam logic [2:0] REG_ROWS_M       = 3'd0;
   localparam logic [2:0] REG_DEPTH_K      = 3'd1;
   localparam logic [2:0] REG_COLS_N       = 3'd2;
   localparam logic [2:0] REG_B_TRANSPOSED = 3'd3;
   localparam logic [2:0] REG_BIAS_ENABLE  = 3'd4;

   // unpacked binary32 operand: value = sig * 2^(expo-23), sig[23] set when finite and nonzero
   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        zero;
      logic        sign;
      logic [9:0]  expo;
      logic [23:0] sig;
   } fop_type;

   // aligned sum held between the two halves of the adder
   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        inf_sign;
      logic        pass;
      fop_type     pass_op;
      logic        sign;
      logic [9:0]  expo;
      logic [27:0] sum;
   } fadd_stage_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_ADD,
      ST_NORM,
      ST_BIAS_READ,
      ST_BIAS_OP,
      ST_CONV
   } fmm_state_type;

endpackage

// ----- hw/rtl/fmm_ram.sv -----
// Single-port-write, single-port-read RAM with registered read data.
module fmm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/fmm_fadd.sv -----
// Shared binary32 adder: align and add, register, then normalise and round.
module fmm_fadd (
   input  logic             clock,
   input  logic             stage_en,
   input  fmm_pkg::fop_type op_a,
   input  fmm_pkg::fop_type op_b,
   output fmm_pkg::fop_type result
);

   fmm_pkg::fadd_stage_type stage_in, stage_ff;

   always_comb begin
      fmm_pkg::fop_type big, lit;
      logic             a_gt;
      logic [9:0]       d;
      logic [26:0]      big27, lit_ext, lit27, lost_mask;
      big      = op_a;
      lit      = op_b;
      a_gt     = 1'b0;
      d        = '0;
      big27    = '0;
      lit_ext  = '0;
      lit27    = '0;
      lost_mask = '0;
      stage_in = '0;
      stage_in.nan = op_a.nan | op_b.nan |
                     (op_a.inf & op_b.inf & (op_a.sign != op_b.sign));
      stage_in.inf = op_a.inf | op_b.inf;
      stage_in.inf_sign = op_a.inf ? op_a.sign : op_b.sign;
      if (op_b.zero) begin
         stage_in.pass = 1'b1;
         stage_in.pass_op = op_a;
         if (op_a.zero) begin
            stage_in.pass_op.sign = op_a.sign & op_b.sign;
         end
      end else if (op_a.zero) begin
         stage_in.pass = 1'b1;
         stage_in.pass_op = op_b;
      end else begin
         a_gt = ($signed(op_a.expo) > $signed(op_b.expo)) ||
                ((op_a.expo == op_b.expo) && (op_a.sig >= op_b.sig));
         big = a_gt ? op_a : op_b;
         lit = a_gt ? op_b : op_a;
         d = big.expo - lit.expo;
         big27 = {big.sig, 3'b000};
         lit_ext = {lit.sig, 3'b000};
         if (d >= 10'd27) begin
            lit27 = 27'd1;
         end else begin
            lost_mask = ~({27{1'b1}} << d[4:0]);
            lit27 = lit_ext >> d[4:0];
            lit27[0] = lit27[0] | (|(lit_ext & lost_mask));
         end
         stage_in.sign = big.sign;
         stage_in.expo = big.expo;
         if (big.sign != lit.sign) begin
            stage_in.sum = {1'b0, big27} - {1'b0, lit27};
         end else begin
            stage_in.sum = {1'b0, big27} + {1'b0, lit27};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      logic [26:0] s27;
      logic [4:0]  lz;
      logic        found;
      logic [9:0]  ex;
      logic [24:0] mant25;
      s27    = '0;
      lz     = '0;
      found  = 1'b0;
      ex     = stage_ff.expo;
      mant25 = '0;
      result = '0;
      if (stage_ff.nan) begin
         result.nan = 1'b1;
      end else if (stage_ff.inf) begin
         result.inf  = 1'b1;
         result.sign = stage_ff.inf_sign;
      end else if (stage_ff.pass) begin
         result = stage_ff.pass_op;
      end else if (stage_ff.sum == '0) begin
         result.zero = 1'b1;
      end else begin
         if (stage_ff.sum[27]) begin
            s27 = {stage_ff.sum[27:2], stage_ff.sum[1] | stage_ff.sum[0]};
            ex  = stage_ff.expo + 10'd1;
         end else begin
            for (int i = 0; i < 27; i++) begin
               if (stage_ff.sum[26-i] && !found) begin
                  lz    = 5'(i);
                  found = 1'b1;
               end
            end
            s27 = stage_ff.sum[26:0] << lz;
            ex  = stage_ff.expo - 10'(lz);
         end
         mant25 = {1'b0, s27[26:3]};
         if (s27[2] && (s27[1] || s27[0] || s27[3])) begin
            mant25 = mant25 + 25'd1;
         end
         result.sign = stage_ff.sign;
         if (mant25[24]) begin
            result.sig  = 24'h800000;
            result.expo = ex + 10'd1;
         end else begin
            result.sig  = mant25[23:0];
            result.expo = ex;
         end
      end
   end

endmodule

// ----- hw/rtl/fp16_matmul_fp32_accumulate.sv -----
// Top level of the half-precision matrix product with binary32 accumulation.
//
// Usage. Items enter on req_* when start is high and busy is low. Modes 0, 1
// and 2 write one binary16 element of A, B or the bias row; a load finishes
// in its accept cycle and busy stays low. Mode 3 computes one result element
// (row, column): the dot product over depth_k is accumulated in binary32 by
// one shared adder, then the bias is added if enabled and the sum is rounded
// to binary16.
// A compute item runs, for each inner-dimension step, a store read, a
// multiply, an align/add and a normalise/round through the shared adder;
// with the bias enabled, a bias read and a bias operand step follow, then
// the same add steps; last comes a conversion state. busy is high throughout
// and rsp_valid pulses in the following cycle; no new item is taken while
// busy. Out-of-range compute items give no result and leave busy low.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Registers sit on an APB-style port at byte address 4*index, pready always
// high. Synchronous reset returns the sequencer to idle and the registers to
// their defaults; the element stores keep whatever they held.
module fp16_matmul_fp32_accumulate #(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_DEPTH = 256,
   parameter int MAX_COLS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_row_index,
   input  logic [7:0]  req_col_index,
   input  logic [15:0] req_elem_value,
   output logic        rsp_valid,
   output logic [5:0]  rsp_out_row,
   output logic [5:0]  rsp_out_col,
   output logic [15:0] rsp_out_value,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AAW = (MAX_ROWS * MAX_DEPTH > 1) ? $clog2(MAX_ROWS * MAX_DEPTH) : 1;
   localparam int BAW = (MAX_COLS * MAX_DEPTH > 1) ? $clog2(MAX_COLS * MAX_DEPTH) : 1;
   localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int KW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int MW  = $clog2(MAX_ROWS + 1);
   localparam int KDW = $clog2(MAX_DEPTH + 1);
   localparam int NW  = $clog2(MAX_COLS + 1);

   // configuration
   logic [6:0] rows_m_ff, cols_n_ff;
   logic [8:0] depth_k_ff;
   logic       b_transposed_ff, bias_enable_ff;
   logic       cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff       <= 7'd64;
         depth_k_ff      <= 9'd256;
         cols_n_ff       <= 7'd64;
         b_transposed_ff <= 1'b0;
         bias_enable_ff  <= 1'b0;
      end else if (cfg_write) begin
         case (paddr[4:2])
            fmm_pkg::REG_ROWS_M:       rows_m_ff       <= pwdata[6:0];
            fmm_pkg::REG_DEPTH_K:      depth_k_ff      <= pwdata[8:0];
            fmm_pkg::REG_COLS_N:       cols_n_ff       <= pwdata[6:0];
            fmm_pkg::REG_B_TRANSPOSED: b_transposed_ff <= pwdata[0];
            fmm_pkg::REG_BIAS_ENABLE:  bias_enable_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         fmm_pkg::REG_ROWS_M:       prdata = {25'd0, rows_m_ff};
         fmm_pkg::REG_DEPTH_K:      prdata = {23'd0, depth_k_ff};
         fmm_pkg::REG_COLS_N:       prdata = {25'd0, cols_n_ff};
         fmm_pkg::REG_B_TRANSPOSED: prdata = {31'd0, b_transposed_ff};
         fmm_pkg::REG_BIAS_ENABLE:  prdata = {31'd0, bias_enable_ff};
         default:                   prdata = '0;
      endcase
   end

   // effective dimensions: zero acts as one, large values clamp to the maximum
   logic [MW-1:0]  m_dim;
   logic [KDW-1:0] k_dim;
   logic [NW-1:0]  n_dim;

   assign m_dim = (rows_m_ff == '0) ? MW'(1) :
                  (rows_m_ff > MAX_ROWS) ? MW'(MAX_ROWS) : MW'(rows_m_ff);
   assign k_dim = (depth_k_ff == '0) ? KDW'(1) :
                  (depth_k_ff > MAX_DEPTH) ? KDW'(MAX_DEPTH) : KDW'(depth_k_ff);
   assign n_dim = (cols_n_ff == '0) ? NW'(1) :
                  (cols_n_ff > MAX_COLS) ? NW'(MAX_COLS) : NW'(cols_n_ff);

   // widen binary16 to the unpacked binary32 form
   function automatic fmm_pkg::fop_type widen(input logic [15:0] h);
      fmm_pkg::fop_type o;
      logic [4:0]       e;
      logic [9:0]       m;
      int               p;
      logic [10:0]      s11;
      o   = '0;
      p   = 0;
      s11 = '0;
      e   = h[14:10];
      m   = h[9:0];
      o.sign = h[15];
      if (e == 5'd31) begin
         o.inf = (m == '0);
         o.nan = (m != '0);
      end else if (e == 5'd0) begin
         if (m == '0) begin
            o.zero = 1'b1;
         end else begin
            for (int i = 0; i < 10; i++) begin
               if (m[i]) p = i;
            end
            s11    = {1'b0, m} << (10 - p);
            o.expo = 10'(p - 24);
            o.sig  = {s11, 13'd0};
         end
      end else begin
         o.expo = 10'(int'(e) - 15);
         o.sig  = {1'b1, m, 13'd0};
      end
      return o;
   endfunction

   // round the unpacked binary32 value to binary16, nearest even
   function automatic logic [15:0] to_half(input fmm_pkg::fop_type o);
      int          ex;
      int          sh;
      logic [24:0] sig, q, rem, halfway;
      logic [15:0] r;
      ex = int'($signed(o.expo));
      sh = 13;
      sig = {1'b0, o.sig};
      q = '0;
      rem = '0;
      halfway = '0;
      if (o.nan) begin
         r = 16'h7E00;
      end else if (o.inf || (!o.zero && ex > 15)) begin
         r = {o.sign, 15'h7C00};
      end else if (o.zero || ex < -25) begin
         r = {o.sign, 15'd0};
      end else begin
         sh = (ex >= -14) ? 13 : (-1 - ex);
         q = sig >> sh;
         rem = sig & ((25'd1 << sh) - 25'd1);
         halfway = 25'd1 << (sh - 1);
         if ((rem > halfway) || ((rem == halfway) && q[0])) begin
            q = q + 25'd1;
         end
         if (ex >= -14) begin
            q = q + 25'((ex + 14) << 10);
         end
         r = {o.sign, q[14:0]};
      end
      return r;
   endfunction

   // sequencer state
   fmm_pkg::fmm_state_type state_ff, state_in;
   logic [7:0]       row_ff, row_in, col_ff, col_in;
   logic [KW-1:0]    k_ff, k_in;
   logic             bias_ff, bias_in;
   fmm_pkg::fop_type acc_ff, acc_in, prod_ff, prod_in, sum;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_value_ff, rsp_value_in;

   logic             accept;
   logic             a_we, b_we, c_we;
   logic [7:0]       b_k, b_n;
   logic [AAW-1:0]   a_raddr, a_waddr;
   logic [BAW-1:0]   b_raddr, b_waddr;
   logic [CAW-1:0]   c_raddr, c_waddr;
   logic [15:0]      a_rd, b_rd, c_rd;

   assign busy   = (state_ff != fmm_pkg::ST_IDLE);
   assign accept = start & ~busy;

   assign b_k = b_transposed_ff ? req_col_index : req_row_index;
   assign b_n = b_transposed_ff ? req_row_index : req_col_index;

   assign a_we = accept && (req_mode == fmm_pkg::MODE_LOAD_A) &&
                 (req_row_index < m_dim) && (req_col_index < k_dim);
   assign b_we = accept && (req_mode == fmm_pkg::MODE_LOAD_B) &&
                 (b_k < k_dim) && (b_n < n_dim);
   assign c_we = accept && (req_mode == fmm_pkg::MODE_LOAD_BIAS) &&
                 (req_col_index < n_dim);

   assign a_waddr = AAW'(32'(req_row_index) * MAX_DEPTH + 32'(req_col_index));
   assign b_waddr = BAW'(32'(b_n) * MAX_DEPTH + 32'(b_k));
   assign c_waddr = CAW'(req_col_index);
   assign a_raddr = AAW'(32'(row_ff) * MAX_DEPTH + 32'(k_ff));
   assign b_raddr = BAW'(32'(col_ff) * MAX_DEPTH + 32'(k_ff));
   assign c_raddr = CAW'(col_ff);

   fmm_ram #(.DEPTH(MAX_ROWS * MAX_DEPTH), .WIDTH(16), .AW(AAW)) u_a_store (
      .clock(clock), .we(a_we), .waddr(a_waddr), .wdata(req_elem_value),
      .raddr(a_raddr), .rdata(a_rd)
   );

   fmm_ram #(.DEPTH(MAX_COLS * MAX_DEPTH), .WIDTH(16), .AW(BAW)) u_b_store (
      .clock(clock), .we(b_we), .waddr(b_waddr), .wdata(req_elem_value),
      .raddr(b_raddr), .rdata(b_rd)
   );

   fmm_ram #(.DEPTH(MAX_COLS), .WIDTH(16), .AW(CAW)) u_bias_store (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(req_elem_value),
      .raddr(c_raddr), .rdata(c_rd)
   );

   fmm_fadd u_fadd (
      .clock(clock),
      .stage_en(state_ff == fmm_pkg::ST_ADD),
      .op_a(acc_ff),
      .op_b(prod_ff),
      .result(sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff       <= row_in;
      col_ff       <= col_in;
      k_ff         <= k_in;
      bias_ff      <= bias_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_comb begin
      fmm_pkg::fop_type pa, pb;
      logic [21:0]      p22;
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      bias_in      = bias_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      pa  = widen(a_rd);
      pb  = widen(b_rd);
      p22 = pa.sig[23:13] * pb.sig[23:13];
      case (state_ff)
         fmm_pkg::ST_IDLE: begin
            if (accept && (req_mode == fmm_pkg::MODE_COMPUTE) &&
                (req_row_index < m_dim) && (req_col_index < n_dim)) begin
               row_in      = req_row_index;
               col_in      = req_col_index;
               k_in        = '0;
               bias_in     = 1'b0;
               acc_in      = '0;
               acc_in.zero = 1'b1;
               state_in    = fmm_pkg::ST_READ;
            end
         end
         fmm_pkg::ST_READ: state_in = fmm_pkg::ST_MUL;
         fmm_pkg::ST_MUL: begin
            // product of two binary16 values is exact in binary32
            prod_in      = '0;
            prod_in.sign = pa.sign ^ pb.sign;
            prod_in.nan  = pa.nan | pb.nan | (pa.inf & pb.zero) | (pb.inf & pa.zero);
            prod_in.inf  = (pa.inf | pb.inf) & ~prod_in.nan;
            prod_in.zero = (pa.zero | pb.zero) & ~prod_in.nan & ~prod_in.inf;
            if (p22[21]) begin
               prod_in.sig  = {p22, 2'b00};
               prod_in.expo = pa.expo + pb.expo + 10'd1;
            end else begin
               prod_in.sig  = {p22[20:0], 3'b000};
               prod_in.expo = pa.expo + pb.expo;
            end
            state_in = fmm_pkg::ST_ADD;
         end
         fmm_pkg::ST_ADD: state_in = fmm_pkg::ST_NORM;
         fmm_pkg::ST_NORM: begin
            acc_in = sum;
            if (bias_ff) begin
               state_in = fmm_pkg::ST_CONV;
            end else if (32'(k_ff) + 32'd1 == 32'(k_dim)) begin
               state_in = bias_enable_ff ? fmm_pkg::ST_BIAS_READ : fmm_pkg::ST_CONV;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = fmm_pkg::ST_READ;
            end
         end
         fmm_pkg::ST_BIAS_READ: state_in = fmm_pkg::ST_BIAS_OP;
         fmm_pkg::ST_BIAS_OP: begin
            prod_in  = widen(c_rd);
            bias_in  = 1'b1;
            state_in = fmm_pkg::ST_ADD;
         end
         fmm_pkg::ST_CONV: begin
            rsp_value_in = to_half(acc_ff);
            rsp_valid_in = 1'b1;
            state_in     = fmm_pkg::ST_IDLE;
         end
         default: state_in = fmm_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = row_ff[5:0];
   assign rsp_out_col   = col_ff[5:0];
   assign rsp_out_value = rsp_value_ff;

`include "fp16_matmul_fp32_accumulate_assert.svh"

   `FMM_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid, !busy)
   `FMM_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `FMM_ASSERT_NEXT(a_load_one_cycle, clock, reset,
      start && !busy && (req_mode != fmm_pkg::MODE_COMPUTE), !busy && !rsp_valid)
   `FMM_ASSERT_NOW(a_norm_after_add, clock, reset,
      state_ff == fmm_pkg::ST_NORM, $past(state_ff) == fmm_pkg::ST_ADD)

endmodule
